// ----- src/refatt_pkg.sv -----
// Shared types and constants for the reference-counted attachment table.
package refatt_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned KeyBitsDef    = 10;

  // Port field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned KeyW    = 10;
  localparam int unsigned FlagsW  = 16;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned LenW    = 6;

  localparam int unsigned TypeW  = 16;
  localparam int unsigned CountW = 8;

  localparam logic [TypeW-1:0]  GeneratedFlag = 16'h0200;
  localparam logic [CountW-1:0] CountMax      = 8'hFF;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_ADD_GEN   = 3'd1,
    CMD_ADD_SURF  = 3'd2,
    CMD_ADD_BONE  = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_FIND_BONE = 3'd5,
    CMD_FIND_SURF = 3'd6
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_REJECTED  = 3'd2,
    STS_FULL      = 3'd3,
    STS_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD_NEW,
    ST_RM_RD,
    ST_RM_EV,
    ST_TRIM_RD,
    ST_TRIM_EV,
    ST_OUT
  } state_e;

endpackage

// ----- src/refatt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module refatt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/refcounted_attach_table.sv -----
// Reference-counted attachment table: slot RAM plus a sequencer that walks it.
// Clear, rejected add, out-of-range remove and command 7 go straight to the result. Find
// and add scan slots from 0 up to the first hit or to length; an add with no hit then writes
// the first empty slot seen or appends. Remove decrements the indexed slot and, when the
// count reaches zero, trims empty slots off the end. An output stall holds the result state.
// One command at a time: the next word is taken the cycle after the result loads; reset
// clears the length and control state, not the slot RAM (slots at or above length unread).
module refcounted_attach_table #(
  parameter int unsigned TABLE_DEPTH = refatt_pkg::TableDepthDef,
  parameter int unsigned KEY_BITS    = refatt_pkg::KeyBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [refatt_pkg::CmdW-1:0]       command_i,
  input  logic [refatt_pkg::KeyW-1:0]       key_i,
  input  logic [refatt_pkg::FlagsW-1:0]     flags_i,
  input  logic [refatt_pkg::SizeW-1:0]      surface_list_size_i,
  input  logic signed [refatt_pkg::IndexW-1:0] index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [refatt_pkg::StatusW-1:0]    status_o,
  output logic [refatt_pkg::SlotW-1:0]      slot_o,
  output logic [refatt_pkg::LenW-1:0]       list_length_o
);
  import refatt_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned LW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW   = KEY_BITS + 1;
  localparam int unsigned EW   = 2 * KW + TypeW + CountW;
  localparam int unsigned CW   = (LW > IndexW) ? LW : IndexW;
  localparam int unsigned SW   = (AW > SlotW) ? AW : SlotW;
  localparam int unsigned KCW  = (KEY_BITS > SizeW) ? KEY_BITS : SizeW;
  localparam logic [KW-1:0] NoKey = {KW{1'b1}};

  // Sequencer state
  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [FlagsW-1:0]   flags_q, flags_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [LW-1:0]       len_q, len_d;
  logic [LW-1:0]       iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic                emp_vld_q, emp_vld_d;
  logic [AW-1:0]       emp_idx_q, emp_idx_d;
  status_e             res_sts_q, res_sts_d;
  logic [AW-1:0]       res_slot_q, res_slot_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [LenW-1:0]     len_out_q, len_out_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  refatt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Input key, low KEY_BITS of the port
  logic [KEY_BITS-1:0] key_in;
  for (genvar k = 0; k < KEY_BITS; k++) begin : g_key
    if (k < KeyW) begin : g_bit
      assign key_in[k] = key_i[k];
    end else begin : g_zero
      assign key_in[k] = 1'b0;
    end
  end

  // Entry fields
  logic [KW-1:0]     ent_sk, ent_bk, sel_key, key_ext;
  logic [TypeW-1:0]  ent_ty;
  logic [CountW-1:0] ent_cnt, cnt_inc, cnt_dec;
  logic              ent_empty;

  assign ent_sk    = ram_rdata[EW-1 -: KW];
  assign ent_bk    = ram_rdata[EW-KW-1 -: KW];
  assign ent_ty    = ram_rdata[CountW +: TypeW];
  assign ent_cnt   = ram_rdata[CountW-1:0];
  assign ent_empty = (ent_sk == NoKey) && (ent_bk == NoKey);
  assign cnt_inc   = (ent_cnt == CountMax) ? ent_cnt : ent_cnt + CountW'(1);
  assign cnt_dec   = ent_cnt - CountW'(1);
  assign key_ext   = {1'b0, key_q};

  logic is_add, is_bone, hit, issue, scan_end, out_free, in_acc;

  assign is_add  = (cmd_q == CMD_ADD_GEN) || (cmd_q == CMD_ADD_SURF) ||
                   (cmd_q == CMD_ADD_BONE);
  assign is_bone = (cmd_q == CMD_ADD_BONE) || (cmd_q == CMD_FIND_BONE);
  assign sel_key = is_bone ? ent_bk : ent_sk;
  // key_ext never equals NoKey, so key-less slots cannot match
  assign hit     = rd_vld_q && (sel_key == key_ext) &&
                   ((cmd_q != CMD_FIND_SURF) || ((ent_ty & flags_q) == flags_q));
  assign issue    = (iss_q < len_q);
  assign scan_end = !rd_vld_q && !issue;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);

  // Accept-time decode
  logic key_rejected, idx_none, idx_bad;
  assign key_rejected = KCW'(key_in) >= KCW'(surface_list_size_i);
  assign idx_none     = ($unsigned(index_i) == {IndexW{1'b1}});
  assign idx_bad      = index_i[IndexW-1] ||
                        (CW'($unsigned(index_i[IndexW-2:0])) >= CW'(len_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_ADD_GEN:   state_d = key_rejected ? ST_OUT : ST_SCAN;
            CMD_ADD_SURF,
            CMD_ADD_BONE,
            CMD_FIND_BONE,
            CMD_FIND_SURF: state_d = ST_SCAN;
            CMD_REMOVE:    state_d = (idx_none || idx_bad) ? ST_OUT : ST_RM_RD;
            default:       state_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_OUT;
        end else if (scan_end) begin
          state_d = is_add ? ST_ADD_NEW : ST_OUT;
        end
      end
      ST_ADD_NEW: state_d = ST_OUT;
      ST_RM_RD:   state_d = ST_RM_EV;
      ST_RM_EV: begin
        if (!ent_empty && (ent_cnt != '0) && (cnt_dec == '0)) begin
          state_d = ST_TRIM_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_TRIM_RD: state_d = (len_q == '0) ? ST_OUT : ST_TRIM_EV;
      ST_TRIM_EV: state_d = ent_empty ? ST_TRIM_RD : ST_OUT;
      ST_OUT:     state_d = out_free ? ST_IDLE : ST_OUT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_d      = cmd_q;
    key_d      = key_q;
    flags_d    = flags_q;
    idx_d      = idx_q;
    len_d      = len_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    emp_vld_d  = emp_vld_q;
    emp_idx_d  = emp_idx_q;
    res_sts_d  = res_sts_q;
    res_slot_d = res_slot_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d      = cmd_e'(command_i);
          key_d      = key_in;
          flags_d    = flags_i;
          idx_d      = AW'(CW'($unsigned(index_i[IndexW-2:0])));
          iss_d      = '0;
          emp_vld_d  = 1'b0;
          res_slot_d = '0;
          res_sts_d  = STS_NOT_FOUND;
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              len_d     = '0;
              res_sts_d = STS_OK;
            end
            CMD_ADD_GEN: begin
              if (key_rejected) begin
                res_sts_d = STS_REJECTED;
              end
            end
            CMD_REMOVE: begin
              if (!idx_none && idx_bad) begin
                res_sts_d = STS_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, each evaluated in the cycle after it issues
        if (!hit && issue) begin
          ram_re    = 1'b1;
          ram_raddr = iss_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_q[AW-1:0];
          iss_d     = iss_q + LW'(1);
        end
        if (rd_vld_q && ent_empty && !emp_vld_q) begin
          emp_vld_d = 1'b1;
          emp_idx_d = rd_idx_q;
        end
        if (hit) begin
          res_sts_d  = STS_OK;
          res_slot_d = rd_idx_q;
          if (is_add) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_q;
            ram_wdata = {ent_sk, ent_bk, ent_ty, cnt_inc};
          end
        end
      end
      ST_ADD_NEW: begin
        ram_wdata = {is_bone ? NoKey : key_ext,
                     is_bone ? key_ext : NoKey,
                     (cmd_q == CMD_ADD_GEN) ? GeneratedFlag : '0,
                     CountW'(1)};
        if (emp_vld_q) begin
          ram_we     = 1'b1;
          ram_waddr  = emp_idx_q;
          res_sts_d  = STS_OK;
          res_slot_d = emp_idx_q;
        end else if (len_q == LW'(TABLE_DEPTH)) begin
          res_sts_d = STS_FULL;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = len_q[AW-1:0];
          res_sts_d  = STS_OK;
          res_slot_d = len_q[AW-1:0];
          len_d      = len_q + LW'(1);
        end
      end
      ST_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      ST_RM_EV: begin
        if (ent_empty || (ent_cnt == '0)) begin
          res_sts_d = STS_BAD_INDEX;
        end else begin
          res_sts_d  = STS_OK;
          res_slot_d = idx_q;
          ram_we     = 1'b1;
          ram_waddr  = idx_q;
          if (cnt_dec == '0) begin
            ram_wdata = {NoKey, NoKey, ent_ty, cnt_dec};
          end else begin
            ram_wdata = {ent_sk, ent_bk, ent_ty, cnt_dec};
          end
        end
      end
      ST_TRIM_RD: begin
        // the emptying write landed last cycle, so this read sees it
        if (len_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(len_q - LW'(1));
        end
      end
      ST_TRIM_EV: begin
        if (ent_empty) begin
          len_d = len_q - LW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    len_out_d   = len_out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
      status_d    = res_sts_q;
      slot_d      = SlotW'(SW'(res_slot_q));
      len_out_d   = LenW'(CW'(len_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      emp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      emp_vld_q   <= emp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    flags_q    <= flags_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    emp_idx_q  <= emp_idx_d;
    res_sts_q  <= res_sts_d;
    res_slot_q <= res_slot_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    len_out_q  <= len_out_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign list_length_o = len_out_q;

endmodule
